// File: rtl/fps_pkg.sv
package fps_pkg;

   // field widths
   localparam int TREE_W  = 6;
   localparam int LEAF_W  = 8;
   localparam int VAL_W   = 24;
   localparam int ADDR_W  = TREE_W + LEAF_W;
   localparam int TABLE_DEPTH = 1 << ADDR_W;

   // leaf table word: valid, variance, mean
   localparam int ENTRY_W = 2 * VAL_W + 1;

   // accumulators
   localparam int CNT_W   = 7;
   localparam int SUM_W   = 31;
   localparam int SQ_W    = 56;
   localparam int WORD_W  = 64;
   localparam int DEN_W   = 2 * CNT_W;
   localparam int STEP_W  = 6;
   localparam int VAR_SHIFT = 12;

   localparam logic [CNT_W-1:0] COUNT_MAX = '1;
   localparam logic [VAL_W-1:0] SPREAD_MAX = '1;

   // stream payload widths
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 48;

   // item kinds and spread modes
   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_VOTE   = 1'b1;
   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_TOTAL  = 1'b1;

   // step counts of the shared unit loops (value is count minus one)
   localparam logic [STEP_W-1:0] STEPS_MU   = STEP_W'(VAL_W - 1);
   localparam logic [STEP_W-1:0] STEPS_CNT  = STEP_W'(CNT_W - 1);
   localparam logic [STEP_W-1:0] STEPS_SUM  = STEP_W'(SUM_W - 2);
   localparam logic [STEP_W-1:0] STEPS_DIV  = STEP_W'(WORD_W - 1);
   localparam logic [STEP_W-1:0] STEPS_SQRT = STEP_W'(WORD_W / 2 - 1);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_VOTE_RD,
      ST_MUL,
      ST_ACC_SQ,
      ST_ACC_VAR,
      ST_FINISH,
      ST_SUB,
      ST_DIV,
      ST_SQRT,
      ST_DONE
   } fps_state_type;

   typedef enum logic [1:0] {
      MUL_MU,
      MUL_NQ,
      MUL_SS,
      MUL_DEN
   } fps_mul_type;

   typedef enum logic {
      DIV_VAR,
      DIV_RESP
   } fps_div_type;

endpackage

// File: rtl/fps_ram.sv
module fps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: rtl/forest_prediction_spread_core.sv
// channel  dir  signals                         payload
// req      in   req_tvalid/tready/tdata/tuser/  tdata: tree, leaf, mean, variance
//               tlast                           tuser: kind, tlast: last tree
// rsp      out  rsp_tvalid/tready/tdata/tuser   tdata: response, spread
//                                               tuser: status
// csr      in   csr_wen/csr_wdata               spread mode
//
// a load beat is written to the table when accepted; a vote beat runs accept, table read,
// 24-step shift-add square and one or two accumulate steps (sample or total mode); a miss
// stops after the read. the last vote then runs n*Q, S*S, the denominator, a 64-step divide,
// a 32-step square root and a 64-step divide for the mean, all on one shared 64-bit adder.
// after reset all 16384 leaf table entries are cleared, one entry a cycle, with req_tready low.
// the result sits in an output register; a following result waits only if rsp is still stalled.
module forest_prediction_spread_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tree [5:0], leaf [13:6], mean [37:14], variance [61:38], zero pad
   input  logic [fps_pkg::REQ_DATA_W-1:0]     req_tdata,
   // kind [0]
   input  logic                               req_tuser,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // response [23:0], spread [47:24]
   output logic [fps_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // status [0]
   output logic                               rsp_tuser,
   input  logic                               csr_wen,
   input  logic                               csr_wdata
);

   import fps_pkg::*;

   fps_state_type             state_ff, state_in;
   fps_mul_type               mul_tag_ff, mul_tag_in;
   fps_div_type               div_tag_ff, div_tag_in;
   logic [ADDR_W-1:0]         clr_addr_ff, clr_addr_in;
   logic                      mode_ff, mode_in;
   logic signed [SUM_W-1:0]   sum_means_ff, sum_means_in;
   logic [SQ_W-1:0]           sum_sq_ff, sum_sq_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      miss_ff, miss_in;
   logic                      last_ff, last_in;
   logic [VAL_W-1:0]          leaf_var_ff, leaf_var_in;
   logic [WORD_W-1:0]         work_ff, work_in;
   logic [WORD_W-1:0]         opnd_ff, opnd_in;
   logic [WORD_W-1:0]         aux_ff, aux_in;
   logic [WORD_W-1:0]         hold_ff, hold_in;
   logic [DEN_W-1:0]          den_ff, den_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [VAL_W-1:0]          resp_ff, resp_in;
   logic [VAL_W-1:0]          spread_ff, spread_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]          rsp_resp_ff, rsp_resp_in;
   logic [VAL_W-1:0]          rsp_spread_ff, rsp_spread_in;
   logic                      rsp_status_ff, rsp_status_in;

   // request fields
   logic [TREE_W-1:0]  req_tree;
   logic [LEAF_W-1:0]  req_leaf;
   logic [VAL_W-1:0]   req_mean;
   logic [VAL_W-1:0]   req_var;
   logic [ADDR_W-1:0]  req_addr;

   // leaf table
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_wa;
   logic [ENTRY_W-1:0]  ram_wd;
   logic [ENTRY_W-1:0]  ram_rd;
   logic [VAL_W-1:0]    rd_mean;
   logic [VAL_W-1:0]    rd_var;
   logic                rd_valid;

   // shared adder
   logic [WORD_W-1:0]   add_a;
   logic [WORD_W-1:0]   add_b;
   logic                add_sub;
   logic [WORD_W:0]     add_res;
   logic                borrow;

   // helpers
   logic [VAL_W-1:0]    abs_mu;
   logic [SUM_W-1:0]    abs_sum_full;
   logic [SUM_W-2:0]    abs_sum;
   logic [WORD_W-1:0]   div_t;
   logic [WORD_W-1:0]   sq_rem;
   logic [WORD_W-1:0]   sq_trial;
   logic                step_last;
   logic                q_bit;
   logic [WORD_W-1:0]   quot;
   logic [WORD_W-1:0]   root;
   logic [VAL_W-1:0]    root_sat;
   logic [CNT_W-1:0]    count_dec;

   assign req_tree = req_tdata[TREE_W-1:0];
   assign req_leaf = req_tdata[TREE_W+LEAF_W-1:TREE_W];
   assign req_mean = req_tdata[ADDR_W+VAL_W-1:ADDR_W];
   assign req_var  = req_tdata[ADDR_W+2*VAL_W-1:ADDR_W+VAL_W];
   assign req_addr = {req_tree, req_leaf};

   assign rd_mean  = ram_rd[VAL_W-1:0];
   assign rd_var   = ram_rd[2*VAL_W-1:VAL_W];
   assign rd_valid = ram_rd[ENTRY_W-1];

   fps_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (req_addr),
      .rd_data (ram_rd)
   );

   assign abs_mu       = rd_mean[VAL_W-1] ? (~rd_mean + 1'b1) : rd_mean;
   assign abs_sum_full = sum_means_ff[SUM_W-1] ? SUM_W'(~sum_means_ff + 1'b1)
                                               : SUM_W'(sum_means_ff);
   assign abs_sum      = abs_sum_full[SUM_W-2:0];
   assign count_dec    = count_ff - 1'b1;

   assign div_t    = {work_ff[WORD_W-2:0], opnd_ff[WORD_W-1]};
   assign sq_rem   = {work_ff[WORD_W-3:0], opnd_ff[WORD_W-1:WORD_W-2]};
   assign sq_trial = {aux_ff[WORD_W-3:0], 2'b01};

   // operand select for the shared adder
   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_sub = 1'b0;
      case (state_ff)
         ST_VOTE_RD: begin
            add_a = {{(WORD_W-SUM_W){sum_means_ff[SUM_W-1]}}, sum_means_ff};
            add_b = {{(WORD_W-VAL_W){rd_mean[VAL_W-1]}}, rd_mean};
         end
         ST_MUL: begin
            add_a = work_ff;
            add_b = aux_ff[0] ? opnd_ff : '0;
         end
         ST_ACC_SQ: begin
            add_a = WORD_W'(sum_sq_ff);
            add_b = work_ff;
         end
         ST_ACC_VAR: begin
            add_a = WORD_W'(sum_sq_ff);
            add_b = WORD_W'(leaf_var_ff) << VAR_SHIFT;
         end
         ST_SUB: begin
            add_a   = hold_ff;
            add_b   = work_ff;
            add_sub = 1'b1;
         end
         ST_DIV: begin
            add_a   = div_t;
            add_b   = WORD_W'(den_ff);
            add_sub = 1'b1;
         end
         ST_SQRT: begin
            add_a   = sq_rem;
            add_b   = sq_trial;
            add_sub = 1'b1;
         end
         default: begin
            add_a = '0;
         end
      endcase
   end

   assign add_res = add_sub ? ({1'b0, add_a} - {1'b0, add_b})
                            : ({1'b0, add_a} + {1'b0, add_b});
   assign borrow  = add_res[WORD_W];

   assign step_last = (step_ff == '0);
   assign q_bit     = ~borrow;
   assign quot      = {aux_ff[WORD_W-2:0], q_bit};
   assign root      = {aux_ff[WORD_W-2:0], q_bit};
   assign root_sat  = (|root[WORD_W-1:VAL_W]) ? SPREAD_MAX : root[VAL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         mode_ff      <= MODE_SAMPLE;
         sum_means_ff <= '0;
         sum_sq_ff    <= '0;
         count_ff     <= '0;
         miss_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         mode_ff      <= mode_in;
         sum_means_ff <= sum_means_in;
         sum_sq_ff    <= sum_sq_in;
         count_ff     <= count_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_tag_ff    <= mul_tag_in;
      div_tag_ff    <= div_tag_in;
      last_ff       <= last_in;
      leaf_var_ff   <= leaf_var_in;
      work_ff       <= work_in;
      opnd_ff       <= opnd_in;
      aux_ff        <= aux_in;
      hold_ff       <= hold_in;
      den_ff        <= den_in;
      step_ff       <= step_in;
      resp_ff       <= resp_in;
      spread_ff     <= spread_in;
      rsp_resp_ff   <= rsp_resp_in;
      rsp_spread_ff <= rsp_spread_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      mul_tag_in    = mul_tag_ff;
      div_tag_in    = div_tag_ff;
      clr_addr_in   = clr_addr_ff;
      mode_in       = csr_wen ? csr_wdata : mode_ff;
      sum_means_in  = sum_means_ff;
      sum_sq_in     = sum_sq_ff;
      count_in      = count_ff;
      miss_in       = miss_ff;
      last_in       = last_ff;
      leaf_var_in   = leaf_var_ff;
      work_in       = work_ff;
      opnd_in       = opnd_ff;
      aux_in        = aux_ff;
      hold_in       = hold_ff;
      den_in        = den_ff;
      step_in       = step_ff;
      resp_in       = resp_ff;
      spread_in     = spread_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_resp_in   = rsp_resp_ff;
      rsp_spread_in = rsp_spread_ff;
      rsp_status_in = rsp_status_ff;
      req_tready    = 1'b0;
      ram_we        = 1'b0;
      ram_wa        = req_addr;
      ram_wd        = {1'b1, req_var, req_mean};

      case (state_ff)
         ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_wa      = clr_addr_ff;
            ram_wd      = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == KIND_LOAD) begin
                  ram_we = 1'b1;
               end else begin
                  last_in  = req_tlast;
                  state_in = ST_VOTE_RD;
               end
            end
         end

         ST_VOTE_RD: begin
            if (!rd_valid || count_ff == COUNT_MAX) begin
               if (!rd_valid) begin
                  miss_in = 1'b1;
               end
               state_in = last_ff ? ST_FINISH : ST_IDLE;
            end else begin
               sum_means_in = add_res[SUM_W-1:0];
               leaf_var_in  = rd_var;
               work_in      = '0;
               opnd_in      = WORD_W'(abs_mu);
               aux_in       = WORD_W'(abs_mu);
               step_in      = STEPS_MU;
               mul_tag_in   = MUL_MU;
               state_in     = ST_MUL;
            end
         end

         // shift-add multiply, one multiplier bit a cycle
         ST_MUL: begin
            work_in = add_res[WORD_W-1:0];
            opnd_in = opnd_ff << 1;
            aux_in  = aux_ff >> 1;
            step_in = step_ff - 1'b1;
            if (step_last) begin
               case (mul_tag_ff)
                  MUL_MU: begin
                     state_in = ST_ACC_SQ;
                  end
                  MUL_NQ: begin
                     hold_in    = add_res[WORD_W-1:0];
                     work_in    = '0;
                     opnd_in    = WORD_W'(abs_sum);
                     aux_in     = WORD_W'(abs_sum);
                     step_in    = STEPS_SUM;
                     mul_tag_in = MUL_SS;
                  end
                  MUL_SS: begin
                     state_in = ST_SUB;
                  end
                  MUL_DEN: begin
                     den_in = add_res[DEN_W-1:0];
                     if (add_res[DEN_W-1:0] == '0) begin
                        // single vote in sample mode: variance is zero
                        opnd_in  = '0;
                        work_in  = '0;
                        aux_in   = '0;
                        step_in  = STEPS_SQRT;
                        state_in = ST_SQRT;
                     end else begin
                        work_in    = '0;
                        opnd_in    = hold_ff;
                        aux_in     = '0;
                        step_in    = STEPS_DIV;
                        div_tag_in = DIV_VAR;
                        state_in   = ST_DIV;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_ACC_SQ: begin
            sum_sq_in = add_res[SQ_W-1:0];
            count_in  = count_ff + 1'b1;
            if (mode_ff == MODE_TOTAL) begin
               state_in = ST_ACC_VAR;
            end else begin
               state_in = last_ff ? ST_FINISH : ST_IDLE;
            end
         end

         ST_ACC_VAR: begin
            sum_sq_in = add_res[SQ_W-1:0];
            state_in  = last_ff ? ST_FINISH : ST_IDLE;
         end

         ST_FINISH: begin
            if (count_ff == '0) begin
               resp_in   = '0;
               spread_in = (mode_ff == MODE_TOTAL) ? VAL_W'(1) : '0;
               state_in  = ST_DONE;
            end else begin
               work_in    = '0;
               opnd_in    = WORD_W'(sum_sq_ff);
               aux_in     = WORD_W'(count_ff);
               step_in    = STEPS_CNT;
               mul_tag_in = MUL_NQ;
               state_in   = ST_MUL;
            end
         end

         // numerator n*Q - S*S, floored at zero
         ST_SUB: begin
            hold_in    = borrow ? '0 : add_res[WORD_W-1:0];
            work_in    = '0;
            opnd_in    = WORD_W'(count_ff);
            aux_in     = (mode_ff == MODE_TOTAL) ? WORD_W'(count_ff) : WORD_W'(count_dec);
            step_in    = STEPS_CNT;
            mul_tag_in = MUL_DEN;
            state_in   = ST_MUL;
         end

         // restoring divide, one quotient bit a cycle
         ST_DIV: begin
            work_in = borrow ? div_t : add_res[WORD_W-1:0];
            opnd_in = opnd_ff << 1;
            aux_in  = quot;
            step_in = step_ff - 1'b1;
            if (step_last) begin
               if (div_tag_ff == DIV_VAR) begin
                  opnd_in  = quot;
                  work_in  = '0;
                  aux_in   = '0;
                  step_in  = STEPS_SQRT;
                  state_in = ST_SQRT;
               end else begin
                  resp_in  = sum_means_ff[SUM_W-1] ? (~quot[VAL_W-1:0] + 1'b1)
                                                   : quot[VAL_W-1:0];
                  state_in = ST_DONE;
               end
            end
         end

         // digit-by-digit square root, two radicand bits a cycle
         ST_SQRT: begin
            work_in = borrow ? sq_rem : add_res[WORD_W-1:0];
            opnd_in = opnd_ff << 2;
            aux_in  = root;
            step_in = step_ff - 1'b1;
            if (step_last) begin
               if (mode_ff == MODE_TOTAL && root_sat == '0) begin
                  spread_in = VAL_W'(1);
               end else begin
                  spread_in = root_sat;
               end
               work_in    = '0;
               opnd_in    = WORD_W'(abs_sum);
               aux_in     = '0;
               den_in     = DEN_W'(count_ff);
               step_in    = STEPS_DIV;
               div_tag_in = DIV_RESP;
               state_in   = ST_DIV;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_resp_in   = resp_ff;
               rsp_spread_in = spread_ff;
               rsp_status_in = miss_ff;
               sum_means_in  = '0;
               sum_sq_in     = '0;
               count_in      = '0;
               miss_in       = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_spread_ff, rsp_resp_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

// File: verif/forest_prediction_spread_core_test.sv
`timescale 1ns / 1ps

module forest_prediction_spread_core_test;
   import fps_pkg::*;

   localparam int CLK_HALF       = 4;
   localparam int WATCHDOG_LIMIT = 60000;
   localparam int SETTLE_CYCLES  = 64;
   localparam int DRAIN_CYCLES   = 300;
   localparam int LONG_HOLD      = 3000;
   localparam int REPORT_MAX     = 10;

   typedef struct {
      logic              kind;
      logic [TREE_W-1:0] tree;
      logic [LEAF_W-1:0] leaf;
      logic [VAL_W-1:0]  mu;
      logic [VAL_W-1:0]  sigma2;
      logic              last;
   } leaf_beat_type;

   typedef struct {
      logic [VAL_W-1:0] response;
      logic [VAL_W-1:0] spread;
      logic             status;
   } spread_est_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_wen = 1'b0;
   logic csr_wdata = 1'b0;

   forest_prediction_spread_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #(CLK_HALF);
      clock = 1'b0;
      #(CLK_HALF);
   end

   // stimulus side
   leaf_beat_type beats_pending[$];
   int  loaded_slots[$];
   bit  slot_queued[TABLE_DEPTH];
   int  idle_pct = 0;
   bit  long_hold_arm = 1'b0;

   // prediction side
   logic [VAL_W-1:0] mu_tbl[TABLE_DEPTH];
   logic [VAL_W-1:0] sigma_tbl[TABLE_DEPTH];
   bit   leaf_present[TABLE_DEPTH];
   longint          sum_mu = 0;
   logic [63:0]     sum_sq = '0;
   int              votes_counted = 0;
   bit              vote_missed = 1'b0;
   logic            spread_mode_now = MODE_SAMPLE;
   spread_est_type  due_estimates[$];

   int  mismatches = 0;
   bit  req_taken = 1'b0;
   int  quiet_cycles = 0;
   int  send_gap = 0;
   int  rsp_gap = 0;
   int  long_hold_left = 0;
   bit  long_hold_used = 1'b0;

   function automatic logic [31:0] floor_root(input logic [63:0] x);
      logic [31:0] r;
      logic [63:0] t;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
         t = {32'b0, r | (32'b1 << b)};
         if (t * t <= x) r = t[31:0];
      end
      return r;
   endfunction

   // updates the leaf table or the running sums; a last vote yields one estimate
   task automatic forest_beat(input leaf_beat_type b);
      int unsigned     slot;
      longint          mu;
      longint          resp;
      logic [63:0]     mu_mag, s_mag, n64, nq, s2, num, variance;
      logic [31:0]     root;
      spread_est_type  est;
      slot = 32'({b.tree, b.leaf});
      if (b.kind == KIND_LOAD) begin
         mu_tbl[slot] = b.mu;
         sigma_tbl[slot] = b.sigma2;
         leaf_present[slot] = 1'b1;
         return;
      end
      if (!leaf_present[slot]) begin
         vote_missed = 1'b1;
      end else if (votes_counted < int'(COUNT_MAX)) begin
         mu = longint'($signed(mu_tbl[slot]));
         mu_mag = (mu < 0) ? -mu : mu;
         sum_mu += mu;
         sum_sq += mu_mag * mu_mag;
         if (spread_mode_now == MODE_TOTAL) sum_sq += {40'b0, sigma_tbl[slot]} << VAR_SHIFT;
         votes_counted++;
      end
      if (!b.last) return;

      resp = 0;
      variance = '0;
      if (votes_counted > 0) begin
         n64 = 64'(votes_counted);
         s_mag = (sum_mu < 0) ? -sum_mu : sum_mu;
         nq = n64 * sum_sq;
         s2 = s_mag * s_mag;
         num = (nq > s2) ? nq - s2 : 64'd0;
         resp = sum_mu / longint'(votes_counted);
         if (spread_mode_now == MODE_TOTAL) variance = num / (n64 * n64);
         else if (votes_counted > 1) variance = num / (n64 * (n64 - 1));
      end
      root = floor_root(variance);
      est.response = resp[VAL_W-1:0];
      est.spread = (root > {8'b0, SPREAD_MAX}) ? SPREAD_MAX : root[VAL_W-1:0];
      if (spread_mode_now == MODE_TOTAL && est.spread == '0) est.spread = VAL_W'(1);
      est.status = vote_missed;
      due_estimates.push_back(est);

      sum_mu = 0;
      sum_sq = '0;
      votes_counted = 0;
      vote_missed = 1'b0;
   endtask

   // request driver
   always @(negedge clock) begin : feed_req
      leaf_beat_type nxt;
      if (!req_tvalid || req_taken) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (beats_pending.size() > 0) begin
            nxt = beats_pending.pop_front();
            req_tdata <= {2'b0, nxt.sigma2, nxt.mu, nxt.leaf, nxt.tree};
            req_tuser <= nxt.kind;
            req_tlast <= nxt.last;
            req_tvalid <= 1'b1;
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
               send_gap <= $urandom_range(1, 17);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response sink; the long hold starts with a result waiting
   always @(negedge clock) begin
      if (long_hold_left > 0) begin
         long_hold_left <= long_hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (long_hold_arm && !long_hold_used && rsp_tvalid) begin
         long_hold_used <= 1'b1;
         long_hold_left <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_tready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         rsp_gap <= $urandom_range(0, 16);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin : watch_ports
      leaf_beat_type  beat;
      spread_est_type want;
      req_taken <= req_tvalid && req_tready;
      if (csr_wen) spread_mode_now = csr_wdata;
      if (req_tvalid && req_tready) begin
         beat.kind   = req_tuser;
         beat.tree   = req_tdata[5:0];
         beat.leaf   = req_tdata[13:6];
         beat.mu     = req_tdata[37:14];
         beat.sigma2 = req_tdata[61:38];
         beat.last   = req_tlast;
         forest_beat(beat);
      end
      if (rsp_tvalid && rsp_tready) begin
         if (due_estimates.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected result beat: tdata %h status %b", rsp_tdata, rsp_tuser);
         end else begin
            want = due_estimates.pop_front();
            if (rsp_tdata[23:0] !== want.response || rsp_tdata[47:24] !== want.spread ||
                rsp_tuser !== want.status) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("result mismatch: response %h/%h spread %h/%h status %b/%b (exp/got)",
                           want.response, rsp_tdata[23:0], want.spread, rsp_tdata[47:24],
                           want.status, rsp_tuser);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("forest_prediction_spread_core_test: errors");
         $finish;
      end
   end

   task automatic push_load(input int tree, input int leaf, input logic [VAL_W-1:0] mu,
                            input logic [VAL_W-1:0] sigma2);
      leaf_beat_type b;
      int slot;
      b.kind = KIND_LOAD;
      b.tree = TREE_W'(tree);
      b.leaf = LEAF_W'(leaf);
      b.mu = mu;
      b.sigma2 = sigma2;
      b.last = 1'($urandom_range(0, 1));
      slot = tree * 256 + leaf;
      if (!slot_queued[slot]) begin
         slot_queued[slot] = 1'b1;
         loaded_slots.push_back(slot);
      end
      beats_pending.push_back(b);
   endtask

   task automatic push_vote(input int tree, input int leaf, input bit last);
      leaf_beat_type b;
      b.kind = KIND_VOTE;
      b.tree = TREE_W'(tree);
      b.leaf = LEAF_W'(leaf);
      b.mu = VAL_W'($urandom);
      b.sigma2 = VAL_W'($urandom);
      b.last = last;
      beats_pending.push_back(b);
   endtask

   task automatic push_random_load();
      logic [VAL_W-1:0] mu, sigma2;
      int pick;
      pick = $urandom_range(0, 99);
      // clustered means give small and zero spreads
      if (pick < 40) mu = VAL_W'($urandom_range(0, 15) - 8);
      else mu = VAL_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 30) sigma2 = '0;
      else if (pick < 50) sigma2 = VAL_W'($urandom_range(0, 4095));
      else sigma2 = VAL_W'($urandom);
      push_load($urandom_range(0, 63), $urandom_range(0, 255), mu, sigma2);
   endtask

   task automatic push_loaded_vote(input bit last);
      int slot;
      slot = loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
      push_vote(slot / 256, slot % 256, last);
   endtask

   task automatic queue_random_beats(input int budget);
      int issued, len, pick;
      issued = 0;
      while (issued < budget) begin
         if (loaded_slots.size() == 0 || $urandom_range(0, 99) < 15) begin
            len = $urandom_range(1, 5);
            repeat (len) push_random_load();
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 75) len = $urandom_range(1, 6);
            else if (pick < 95) len = $urandom_range(7, 24);
            else len = $urandom_range(25, 60);
            for (int k = 0; k < len; k++) begin
               // a few votes to arbitrary leaves, mostly misses
               if ($urandom_range(0, 99) < 8)
                  push_vote($urandom_range(0, 63), $urandom_range(0, 255), k == len - 1);
               else
                  push_loaded_vote(k == len - 1);
            end
         end
         issued += len;
      end
   endtask

   task automatic settle();
      while (beats_pending.size() != 0 || req_tvalid || due_estimates.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(input logic mode);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= mode;
      @(negedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_mode(MODE_SAMPLE);

      // directed: field extremes, single tree, misses, zero spread, mode switch
      push_load(0, 0, 24'h7FFFFF, 24'hFFFFFF);
      push_load(63, 255, 24'h800000, 24'h000000);
      push_load(1, 2, 24'h000000, 24'hAAAAAA);
      push_load(2, 3, 24'hFFFFFF, 24'h555555);
      push_load(3, 3, 24'd100, 24'h000000);
      push_vote(0, 0, 1'b1);
      push_vote(0, 0, 1'b0);
      push_vote(63, 255, 1'b1);
      push_vote(5, 5, 1'b1);
      push_vote(1, 2, 1'b0);
      push_vote(7, 7, 1'b0);
      push_vote(2, 3, 1'b1);
      push_vote(63, 255, 1'b0);
      settle();
      set_mode(MODE_TOTAL);
      push_vote(0, 0, 1'b1);
      push_vote(1, 2, 1'b1);
      push_vote(9, 9, 1'b1);
      push_vote(3, 3, 1'b0);
      push_vote(3, 3, 1'b1);
      push_vote(0, 0, 1'b0);
      push_vote(63, 255, 1'b0);
      push_vote(2, 3, 1'b1);
      settle();

      // random, with a long sink stall and an observation past the count limit
      idle_pct = 10;
      long_hold_arm = 1'b1;
      for (int k = 0; k < 132; k++) push_loaded_vote(k == 131);
      queue_random_beats(120);
      settle();
      set_mode(MODE_SAMPLE);
      idle_pct = 30;
      queue_random_beats(170);
      settle();
      set_mode(MODE_TOTAL);
      idle_pct = 0;
      queue_random_beats(150);
      settle();
      set_mode(MODE_SAMPLE);
      idle_pct = 5;
      queue_random_beats(80);
      settle();
      set_mode(MODE_TOTAL);
      idle_pct = 0;
      queue_random_beats(100);

      while (beats_pending.size() != 0 || req_tvalid || due_estimates.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && due_estimates.size() == 0)
         $display("forest_prediction_spread_core_test: clean");
      else
         $display("forest_prediction_spread_core_test: errors");
      $finish;
   end

endmodule
